FILE: src/lru_handle_cache_manager_macros.svh
//------------------------------------------------------------------------------
// lru_handle_cache_manager_macros.svh
// Assertion macros shared by the handle cache manager.
//------------------------------------------------------------------------------
`ifndef LRU_HANDLE_CACHE_MANAGER_MACROS_SVH
`define LRU_HANDLE_CACHE_MANAGER_MACROS_SVH

// clocked check, masked while reset is held
`define LHCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define LHCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/lhcm_pkg.sv
//------------------------------------------------------------------------------
// lhcm_pkg
// Types and constants of the handle cache manager.
//------------------------------------------------------------------------------
package lhcm_pkg;

    localparam int NUM_HANDLES_DEF = 32;
    localparam int NODE_HEADER_DEF = 16;
    localparam int LINK_W          = 6;
    localparam int DATA_W          = 24;
    localparam int OWNER_W         = 16;
    localparam int USED_W          = 25;
    localparam int HANDLE_W        = 8;
    localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;
    localparam logic [DATA_W-1:0] CAP_RESET = 24'd1048576;

    typedef logic [LINK_W-1:0] t_link;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOCK   = 3'd2,
        OP_UNLOCK = 3'd3,
        OP_QUERY  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_NO_ROOM   = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        KIND_UNLOAD = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_FINAL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   size;
        logic [OWNER_W-1:0]  owner;
        t_status             status;
        logic                last;
    } t_res;

    typedef struct packed {
        logic busy;
        logic push;
    } t_ctrl_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_LK_CHK,
        S_WALK,
        S_DROP,
        S_UL0,
        S_UL1,
        S_UL2,
        S_PS0,
        S_PS1,
        S_LOAD,
        S_LK_DONE,
        S_DEL_FIN,
        S_EMIT_FINAL
    } t_state;

endpackage

FILE: src/lhcm_out.sv
//------------------------------------------------------------------------------
// lhcm_out
// Output register: holds one result until the downstream side takes it.
//------------------------------------------------------------------------------
module lhcm_out
    import lhcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_ready,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: src/lhcm_ctrl.sv
//------------------------------------------------------------------------------
// lhcm_ctrl
// Sequencer over the handle table, free list and recency list.
//------------------------------------------------------------------------------
module lhcm_ctrl
    import lhcm_pkg::*;
#(
    parameter int NUM_HANDLES = NUM_HANDLES_DEF,
    parameter int NODE_HEADER = NODE_HEADER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [OWNER_W-1:0]  i_owner_id,
    input  logic [DATA_W-1:0]   i_data_size,
    input  logic                i_size_ok,
    input  logic                i_load_now,
    input  logic                i_cfg_we,
    input  logic [DATA_W-1:0]   i_cfg_wdata,
    input  logic                i_out_ready,
    output t_res                o_res,
    output t_ctrl_stat          o_stat
);

    localparam int IW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam logic [USED_W-1:0] HDR = USED_W'(NODE_HEADER);

    t_state r_state, n_state, r_ret;

    logic [2:0]          r_op;
    logic [HANDLE_W-1:0] r_h;
    logic [OWNER_W-1:0]  r_owner;
    logic [DATA_W-1:0]   r_dsize;
    logic                r_sok, r_now, r_is_create;
    t_link               r_tgt, r_cur, r_ux, r_o, r_n;
    logic [USED_W-1:0]   r_avail, r_need, r_used;
    t_status             r_lst;
    t_res                r_fin;
    logic [DATA_W-1:0]   r_cap;
    t_link               r_free_head, r_newest, r_oldest;

    logic                r_in_use [NUM_HANDLES];
    logic                r_loaded [NUM_HANDLES];
    logic                r_pinned [NUM_HANDLES];
    logic [DATA_W-1:0]   r_bytes  [NUM_HANDLES];
    logic [OWNER_W-1:0]  r_eowner [NUM_HANDLES];
    t_link               r_free   [NUM_HANDLES];
    t_link               r_newer  [NUM_HANDLES];
    t_link               r_older  [NUM_HANDLES];

    t_link               rd_addr;
    logic [IW-1:0]       ra;
    logic                rd_in_use, rd_loaded, rd_pinned;
    logic [DATA_W-1:0]   rd_bytes;
    logic [OWNER_W-1:0]  rd_owner;
    t_link               rd_free, rd_newer, rd_older;
    logic [USED_W-1:0]   rd_node, cap_ext, avail0;
    logic                h_ok, push;

    function automatic logic link_ok(input t_link x);
        return 32'(x) < NUM_HANDLES;
    endfunction

    always_comb begin
        unique case (r_state)
            S_WALK:       rd_addr = r_cur;
            S_DROP, S_UL0: rd_addr = r_ux;
            default:      rd_addr = r_tgt;
        endcase
    end

    assign ra        = rd_addr[IW-1:0];
    assign rd_in_use = r_in_use[ra];
    assign rd_loaded = r_loaded[ra];
    assign rd_pinned = r_pinned[ra];
    assign rd_bytes  = r_bytes[ra];
    assign rd_owner  = r_eowner[ra];
    assign rd_free   = r_free[ra];
    assign rd_newer  = r_newer[ra];
    assign rd_older  = r_older[ra];
    assign rd_node   = {1'b0, rd_bytes} + HDR;
    assign cap_ext   = {1'b0, r_cap};
    assign avail0    = (r_used >= cap_ext) ? '0 : cap_ext - r_used;
    assign h_ok      = 32'(r_h) < NUM_HANDLES;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_DEC;
            S_DEC: begin
                priority case (r_op)
                    OP_CREATE: begin
                        if (!link_ok(r_free_head) || r_owner == '0 || !r_sok) begin
                            n_state = S_EMIT_FINAL;
                        end else if (r_now) begin
                            n_state = S_LK_CHK;
                        end else begin
                            n_state = S_EMIT_FINAL;
                        end
                    end
                    OP_DELETE: begin
                        if (!h_ok || !rd_in_use) n_state = S_EMIT_FINAL;
                        else if (rd_loaded) n_state = S_DROP;
                        else n_state = S_DEL_FIN;
                    end
                    OP_LOCK: begin
                        if (!h_ok || !rd_in_use) n_state = S_EMIT_FINAL;
                        else n_state = S_LK_CHK;
                    end
                    default: n_state = S_EMIT_FINAL;
                endcase
            end
            S_LK_CHK: begin
                if (!rd_loaded) begin
                    if (rd_bytes == '0 || rd_node > cap_ext) n_state = S_LK_DONE;
                    else n_state = S_WALK;
                end else if (r_newest != r_tgt) begin
                    n_state = S_UL0;
                end else begin
                    n_state = S_LK_DONE;
                end
            end
            S_WALK: begin
                if (link_ok(r_cur) && r_avail < r_need) begin
                    if (!rd_pinned) n_state = S_DROP;
                end else if (r_avail < r_need) begin
                    n_state = S_LK_DONE;
                end else begin
                    n_state = S_PS0;
                end
            end
            S_DROP:    if (i_out_ready) n_state = S_UL0;
            S_UL0:     n_state = S_UL1;
            S_UL1:     n_state = S_UL2;
            S_UL2:     n_state = r_ret;
            S_PS0:     n_state = S_PS1;
            S_PS1:     n_state = rd_loaded ? S_LK_DONE : S_LOAD;
            S_LOAD:    if (i_out_ready) n_state = S_LK_DONE;
            S_LK_DONE: n_state = S_EMIT_FINAL;
            S_DEL_FIN: n_state = S_EMIT_FINAL;
            S_EMIT_FINAL: if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        push  = 1'b0;
        o_res = r_fin;
        unique case (r_state)
            S_DROP: begin
                push  = i_out_ready;
                o_res = '{KIND_UNLOAD, HANDLE_W'(r_ux), rd_bytes, rd_owner, ST_OK, 1'b0};
            end
            S_LOAD: begin
                push  = i_out_ready;
                o_res = '{KIND_LOAD, HANDLE_W'(r_tgt), rd_bytes, rd_owner, ST_OK, 1'b0};
            end
            S_EMIT_FINAL: push = i_out_ready;
            default: push = 1'b0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_stat  = '{busy: (r_state != S_IDLE), push: push};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_free_head <= '0;
            r_newest    <= NULL_LINK;
            r_oldest    <= NULL_LINK;
            r_used      <= '0;
            for (int i = 0; i < NUM_HANDLES; i++) begin
                r_in_use[i] <= 1'b0;
                r_loaded[i] <= 1'b0;
                r_pinned[i] <= 1'b0;
                r_bytes[i]  <= '0;
                r_eowner[i] <= '0;
                r_free[i]   <= (i == NUM_HANDLES - 1) ? NULL_LINK : LINK_W'(i + 1);
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op        <= i_op;
                        r_h         <= i_handle;
                        r_owner     <= i_owner_id;
                        r_dsize     <= i_data_size;
                        r_sok       <= i_size_ok;
                        r_now       <= i_load_now;
                        r_is_create <= (i_op == OP_CREATE);
                        r_tgt       <= (i_op == OP_CREATE) ? r_free_head : LINK_W'(i_handle);
                    end
                end
                S_DEC: begin
                    priority case (r_op)
                        OP_CREATE: begin
                            if (!link_ok(r_free_head)) begin
                                r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_NO_FREE, 1'b1};
                            end else if (r_owner == '0 || !r_sok) begin
                                r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_REFUSED, 1'b1};
                            end else begin
                                r_free_head  <= rd_free;
                                r_in_use[ra] <= 1'b1;
                                r_loaded[ra] <= 1'b0;
                                r_pinned[ra] <= 1'b0;
                                r_bytes[ra]  <= r_dsize;
                                r_eowner[ra] <= r_owner;
                                r_fin <= '{KIND_FINAL, HANDLE_W'(r_tgt), r_dsize, r_owner,
                                           ST_OK, 1'b1};
                            end
                        end
                        OP_DELETE: begin
                            r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_BAD_HANDLE, 1'b1};
                            if (h_ok && rd_in_use) begin
                                r_ux  <= r_tgt;
                                r_ret <= S_DEL_FIN;
                            end
                        end
                        OP_UNLOCK: begin
                            if (h_ok && rd_in_use) begin
                                r_pinned[ra] <= 1'b0;
                                r_fin <= '{KIND_FINAL, r_h, rd_bytes, rd_owner, ST_OK, 1'b1};
                            end else begin
                                r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_BAD_HANDLE, 1'b1};
                            end
                        end
                        OP_QUERY: begin
                            if (h_ok) begin
                                r_fin <= '{KIND_FINAL, r_h, rd_bytes, rd_owner, ST_OK, 1'b1};
                            end else begin
                                r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_BAD_HANDLE, 1'b1};
                            end
                        end
                        default: r_fin <= '{KIND_FINAL, r_h, '0, '0, ST_BAD_HANDLE, 1'b1};
                    endcase
                end
                S_LK_CHK: begin
                    r_lst   <= (!rd_loaded && rd_bytes == '0) ? ST_EMPTY :
                               (!rd_loaded && rd_node > cap_ext) ? ST_TOO_LARGE : ST_OK;
                    r_need  <= rd_node;
                    r_avail <= avail0;
                    r_cur   <= r_oldest;
                    r_ux    <= r_tgt;
                    r_ret   <= S_PS0;
                end
                S_WALK: begin
                    if (link_ok(r_cur) && r_avail < r_need) begin
                        r_cur <= rd_newer;
                        if (!rd_pinned) begin
                            r_ux    <= r_cur;
                            r_avail <= r_avail + rd_node;
                            r_ret   <= S_WALK;
                        end
                    end else if (r_avail < r_need) begin
                        r_lst <= ST_NO_ROOM;
                    end
                end
                S_DROP: begin
                    if (i_out_ready) begin
                        r_loaded[ra] <= 1'b0;
                        r_pinned[ra] <= 1'b0;
                        r_used       <= r_used - rd_node;
                    end
                end
                S_UL0: begin
                    r_o <= rd_older;
                    r_n <= rd_newer;
                end
                S_UL1: begin
                    if (link_ok(r_n)) r_older[r_n[IW-1:0]] <= r_o;
                    else r_newest <= r_o;
                end
                S_UL2: begin
                    if (link_ok(r_o)) r_newer[r_o[IW-1:0]] <= r_n;
                    else r_oldest <= r_n;
                end
                S_PS0: begin
                    r_older[ra] <= r_newest;
                    r_newer[ra] <= NULL_LINK;
                end
                S_PS1: begin
                    if (link_ok(r_newest)) r_newer[r_newest[IW-1:0]] <= r_tgt;
                    else r_oldest <= r_tgt;
                    r_newest <= r_tgt;
                end
                S_LOAD: begin
                    if (i_out_ready) begin
                        r_loaded[ra] <= 1'b1;
                        r_used       <= r_used + r_need;
                    end
                end
                S_LK_DONE: begin
                    if (r_lst == ST_OK) begin
                        r_pinned[ra] <= !r_is_create;
                    end
                    if (r_is_create) begin
                        r_fin <= '{KIND_FINAL, HANDLE_W'(r_tgt), r_dsize, r_owner, ST_OK, 1'b1};
                    end else if (r_lst == ST_OK) begin
                        r_fin <= '{KIND_FINAL, r_h, rd_bytes, rd_owner, ST_OK, 1'b1};
                    end else begin
                        r_fin <= '{KIND_FINAL, r_h, '0, '0, r_lst, 1'b1};
                    end
                end
                S_DEL_FIN: begin
                    r_fin <= '{KIND_FINAL, r_h, rd_bytes, rd_owner, ST_OK, 1'b1};
                    r_in_use[ra] <= 1'b0;
                    r_pinned[ra] <= 1'b0;
                    r_bytes[ra]  <= '0;
                    r_eowner[ra] <= '0;
                    r_free[ra]   <= r_free_head;
                    r_free_head  <= r_tgt;
                end
                S_EMIT_FINAL: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/lru_handle_cache_manager.sv
//------------------------------------------------------------------------------
// lru_handle_cache_manager
// Handle table with free list and pinned LRU cache under a byte budget.
//------------------------------------------------------------------------------
//  channel   handshake          payload
//  request   i_valid / o_stall  i_op i_handle i_owner_id i_data_size
//                               i_size_ok i_load_now
//  result    o_valid / i_stall  o_kind o_result_handle o_result_size
//                               o_result_owner o_status o_last
//  config    i_cfg_we           i_cfg_wdata (pool capacity)
//
//  The eviction walk of lock visits one recency list entry per cycle; each
//  entry it evicts first waits in S_DROP for the output to take its notice
//  and then passes through the unlink states S_UL0, S_UL1 and S_UL2.
//  Reset is synchronous and clears the table at once; no clearing pass.
//  A stalled output holds the sequencer at its next notice or response.
//------------------------------------------------------------------------------
`include "lru_handle_cache_manager_macros.svh"

module lru_handle_cache_manager
    import lhcm_pkg::*;
#(
    parameter int NUM_HANDLES = NUM_HANDLES_DEF,
    parameter int NODE_HEADER = NODE_HEADER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [OWNER_W-1:0]  i_owner_id,
    input  logic [DATA_W-1:0]   i_data_size,
    input  logic                i_size_ok,
    input  logic                i_load_now,
    input  logic                i_cfg_we,
    input  logic [DATA_W-1:0]   i_cfg_wdata,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [HANDLE_W-1:0] o_result_handle,
    output logic [DATA_W-1:0]   o_result_size,
    output logic [OWNER_W-1:0]  o_result_owner,
    output logic [2:0]          o_status,
    output logic                o_last
);

    t_res       res_in, res_out;
    t_ctrl_stat stat;
    logic       out_ready;

    lhcm_ctrl #(
        .NUM_HANDLES (NUM_HANDLES),
        .NODE_HEADER (NODE_HEADER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_handle    (i_handle),
        .i_owner_id  (i_owner_id),
        .i_data_size (i_data_size),
        .i_size_ok   (i_size_ok),
        .i_load_now  (i_load_now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (out_ready),
        .o_res       (res_in),
        .o_stat      (stat)
    );

    lhcm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (stat.push),
        .i_res   (res_in),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res_out)
    );

    assign o_kind          = res_out.kind;
    assign o_result_handle = res_out.handle;
    assign o_result_size   = res_out.size;
    assign o_result_owner  = res_out.owner;
    assign o_status        = res_out.status;
    assign o_last          = res_out.last;

    `LHCM_ASSERT(a_push_room, stat.push |-> out_ready, "push into full output")
    `LHCM_ASSERT(a_busy_after_req, (i_valid && !o_stall) |=> stat.busy, "idle after request")
    `LHCM_ASSERT(a_last_is_final, (o_valid && o_last) |-> (o_kind == KIND_FINAL), "last on notice")
    `LHCM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !stat.busy, "busy after reset")

endmodule

FILE: sim/lru_handle_cache_manager_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// lru_handle_cache_manager_tb
// Drives create, delete, lock, unlock and query requests into the handle
// cache manager under random gaps and stalls, predicts the load and unload
// notices and final responses of each request, and checks every result.
//------------------------------------------------------------------------------
module lru_handle_cache_manager_tb;
    import lhcm_pkg::*;

    localparam int NH = 32;
    localparam int HDR = 16;
    localparam int NONE = 63;
    localparam int LIMIT = 4000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [2:0] i_op = OP_QUERY;
    logic [HANDLE_W-1:0] i_handle = 0;
    logic [OWNER_W-1:0] i_owner_id = 0;
    logic [DATA_W-1:0] i_data_size = 0;
    logic i_size_ok = 0;
    logic i_load_now = 0;
    logic i_cfg_we = 0;
    logic [DATA_W-1:0] i_cfg_wdata = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [1:0] o_kind;
    logic [HANDLE_W-1:0] o_result_handle;
    logic [DATA_W-1:0] o_result_size;
    logic [OWNER_W-1:0] o_result_owner;
    logic [2:0] o_status;
    logic o_last;

    lru_handle_cache_manager DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_handle(i_handle), .i_owner_id(i_owner_id),
        .i_data_size(i_data_size), .i_size_ok(i_size_ok), .i_load_now(i_load_now),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_valid(o_valid),
        .i_stall(i_stall), .o_kind(o_kind), .o_result_handle(o_result_handle),
        .o_result_size(o_result_size), .o_result_owner(o_result_owner),
        .o_status(o_status), .o_last(o_last)
    );

    always #2 i_clk = ~i_clk;

    // predicted cache state
    logic [DATA_W-1:0] capacity;
    bit used_q[NH], loaded_q[NH], pin_q[NH];
    logic [DATA_W-1:0] bytes_q[NH];
    logic [OWNER_W-1:0] owner_q[NH];
    int free_next[NH], newer_q[NH], older_q[NH];
    int free_head, newest, oldest;
    logic [USED_W-1:0] used_bytes;

    t_res expected_q[$];
    int errors = 0;
    int cycles = 0;
    bit live_stalls = 1;

    function automatic void push_result(t_kind k, int h, logic [DATA_W-1:0] sz,
                                        logic [OWNER_W-1:0] ow, t_status st);
        t_res r;
        r.kind = k; r.handle = h[7:0]; r.size = sz; r.owner = ow;
        r.status = st; r.last = (k == KIND_FINAL);
        expected_q.push_back(r);
    endfunction

    function automatic void unlink(int i);
        int o, n;
        o = older_q[i]; n = newer_q[i];
        if (n < NH) older_q[n] = o; else newest = o;
        if (o < NH) newer_q[o] = n; else oldest = n;
    endfunction

    function automatic void make_newest(int i);
        older_q[i] = newest;
        newer_q[i] = NONE;
        if (newest < NH) newer_q[newest] = i; else oldest = i;
        newest = i;
    endfunction

    function automatic void evict(int i);
        push_result(KIND_UNLOAD, i, bytes_q[i], owner_q[i], ST_OK);
        unlink(i);
        loaded_q[i] = 0;
        pin_q[i] = 0;
        used_bytes = used_bytes - (USED_W'(bytes_q[i]) + USED_W'(HDR));
    endfunction

    function automatic t_status lock_entry(int i);
        logic [USED_W:0] need, avail;
        int cur, nxt;
        if (!loaded_q[i]) begin
            if (bytes_q[i] == 0) return ST_EMPTY;
            need = bytes_q[i] + HDR;
            if (need > capacity) return ST_TOO_LARGE;
            avail = (used_bytes >= capacity) ? 0 : capacity - used_bytes;
            cur = oldest;
            while (cur < NH && avail < need) begin
                nxt = newer_q[cur];
                if (!pin_q[cur]) begin
                    avail += bytes_q[cur] + HDR;
                    evict(cur);
                end
                cur = nxt;
            end
            if (avail < need) return ST_NO_ROOM;
            make_newest(i);
            loaded_q[i] = 1;
            used_bytes = used_bytes + need[USED_W-1:0];
            push_result(KIND_LOAD, i, bytes_q[i], owner_q[i], ST_OK);
        end else if (newest != i) begin
            unlink(i);
            make_newest(i);
        end
        pin_q[i] = 1;
        return ST_OK;
    endfunction

    function automatic void predict_request(logic [2:0] op, int h, logic [OWNER_W-1:0] ow,
                                            logic [DATA_W-1:0] ds, bit sok, bit now);
        int i;
        t_status st;
        logic [DATA_W-1:0] sz;
        logic [OWNER_W-1:0] o2;
        case (op)
            OP_CREATE: begin
                i = free_head;
                if (i >= NH) push_result(KIND_FINAL, h, 0, 0, ST_NO_FREE);
                else if (ow == 0 || !sok) push_result(KIND_FINAL, h, 0, 0, ST_REFUSED);
                else begin
                    free_head = free_next[i];
                    used_q[i] = 1; loaded_q[i] = 0; pin_q[i] = 0;
                    bytes_q[i] = ds; owner_q[i] = ow;
                    if (now) begin
                        st = lock_entry(i);
                        pin_q[i] = 0;
                    end
                    push_result(KIND_FINAL, i, ds, ow, ST_OK);
                end
            end
            OP_DELETE: begin
                if (h >= NH || !used_q[h]) push_result(KIND_FINAL, h, 0, 0, ST_BAD_HANDLE);
                else begin
                    if (loaded_q[h]) evict(h);
                    sz = bytes_q[h]; o2 = owner_q[h];
                    used_q[h] = 0; pin_q[h] = 0; bytes_q[h] = 0; owner_q[h] = 0;
                    free_next[h] = free_head;
                    free_head = h;
                    push_result(KIND_FINAL, h, sz, o2, ST_OK);
                end
            end
            OP_LOCK: begin
                if (h >= NH || !used_q[h]) push_result(KIND_FINAL, h, 0, 0, ST_BAD_HANDLE);
                else begin
                    st = lock_entry(h);
                    if (st == ST_OK) push_result(KIND_FINAL, h, bytes_q[h], owner_q[h], ST_OK);
                    else push_result(KIND_FINAL, h, 0, 0, st);
                end
            end
            OP_UNLOCK: begin
                if (h >= NH || !used_q[h]) push_result(KIND_FINAL, h, 0, 0, ST_BAD_HANDLE);
                else begin
                    pin_q[h] = 0;
                    push_result(KIND_FINAL, h, bytes_q[h], owner_q[h], ST_OK);
                end
            end
            OP_QUERY: begin
                if (h >= NH) push_result(KIND_FINAL, h, 0, 0, ST_BAD_HANDLE);
                else push_result(KIND_FINAL, h, bytes_q[h], owner_q[h], ST_OK);
            end
            default: push_result(KIND_FINAL, h, 0, 0, ST_BAD_HANDLE);
        endcase
    endfunction

    task automatic send_request(logic [2:0] op, int h, logic [OWNER_W-1:0] ow,
                                logic [DATA_W-1:0] ds, bit sok, bit now);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_op = op; i_handle = h[7:0]; i_owner_id = ow; i_data_size = ds;
        i_size_ok = sok; i_load_now = now; i_valid = 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(op, h, ow, ds, sok, now);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [DATA_W-1:0] v);
        drain();
        i_cfg_we = 1; i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        capacity = v;
    endtask

    // receiver: random stall per result, sample at rising edge
    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            wait_n = live_stalls ? $urandom_range(0, 14) : 0;
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            i_stall = (wait_n != 0);
            while (wait_n > 0) begin
                @(negedge i_clk);
                wait_n--;
                if (wait_n == 0) i_stall = 0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result kind=%0d handle=%0d",
                                           o_kind, o_result_handle);
            end else begin
                e = expected_q.pop_front();
                if (o_kind !== e.kind || o_result_handle !== e.handle ||
                    o_result_size !== e.size || o_result_owner !== e.owner ||
                    o_status !== e.status || o_last !== e.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("mismatch exp k%0d h%0d s%0d o%0d st%0d l%0d ",
                               e.kind, e.handle, e.size, e.owner, e.status, e.last);
                        $display("got k%0d h%0d s%0d o%0d st%0d l%0d",
                                 o_kind, o_result_handle, o_result_size, o_result_owner,
                                 o_status, o_last);
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_handle();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(0, 255);
        if (r == 1) return $urandom_range(NH, 63);
        return $urandom_range(0, NH - 1);
    endfunction

    task automatic test_directed();
        send_request(OP_QUERY, 0, 0, 0, 0, 0);
        send_request(OP_QUERY, 255, 0, 0, 0, 0);
        send_request(OP_CREATE, 7, 0, 100, 1, 0);
        send_request(OP_CREATE, 7, 16'hFFFF, 100, 0, 0);
        send_request(OP_CREATE, 0, 16'hFFFF, 24'hFFFFFF, 1, 1);
        send_request(OP_CREATE, 0, 1, 0, 1, 0);
        send_request(OP_LOCK, 1, 0, 0, 0, 0);
        send_request(OP_CREATE, 0, 16'h1234, 1000, 1, 1);
        send_request(OP_LOCK, 2, 0, 0, 0, 0);
        send_request(OP_LOCK, 2, 0, 0, 0, 0);
        send_request(OP_UNLOCK, 2, 0, 0, 0, 0);
        send_request(OP_UNLOCK, 30, 0, 0, 0, 0);
        send_request(OP_DELETE, 2, 0, 0, 0, 0);
        send_request(OP_DELETE, 2, 0, 0, 0, 0);
        send_request(3'd5, 9, 0, 0, 0, 0);
        send_request(3'd7, 200, 16'hFFFF, 24'hFFFFFF, 1, 1);
        send_request(OP_LOCK, 0, 0, 0, 0, 0);
        send_request(OP_DELETE, 255, 0, 0, 0, 0);
        for (int k = 0; k < NH + 1; k++)
            send_request(OP_CREATE, k, k + 1, k * 7, 1, 0);
    endtask

    task automatic test_eviction();
        write_capacity(200);
        for (int k = 1; k < NH; k++)
            send_request(OP_LOCK, k, 0, 0, 0, 0);
        for (int k = 1; k < NH; k += 2)
            send_request(OP_UNLOCK, k, 0, 0, 0, 0);
        send_request(OP_LOCK, 30, 0, 0, 0, 0);
        write_capacity(0);
        send_request(OP_LOCK, 29, 0, 0, 0, 0);
        write_capacity(24'hFFFFFF);
        for (int k = 0; k < NH; k++)
            send_request(OP_DELETE, k, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        int r;
        logic [DATA_W-1:0] ds;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                live_stalls = 0;
                drain();
                live_stalls = 1;
            end
            r = $urandom_range(0, 99);
            ds = ($urandom_range(0, 9) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 300));
            if (r < 25)
                send_request(OP_CREATE, $urandom_range(0, 255),
                             ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom()),
                             ds, $urandom_range(0, 15) != 0, $urandom_range(0, 1));
            else if (r < 35) send_request(OP_DELETE, pick_handle(), 0, 0, 0, 0);
            else if (r < 70) send_request(OP_LOCK, pick_handle(), 0, 0, 0, 0);
            else if (r < 88) send_request(OP_UNLOCK, pick_handle(), 0, 0, 0, 0);
            else if (r < 97) send_request(OP_QUERY, pick_handle(), 0, 0, 0, 0);
            else send_request(3'($urandom_range(5, 7)), $urandom_range(0, 255),
                              16'($urandom()), 24'($urandom()), 1, 1);
        end
    endtask

    initial begin
        capacity = CAP_RESET;
        for (int k = 0; k < NH; k++) begin
            used_q[k] = 0; loaded_q[k] = 0; pin_q[k] = 0;
            bytes_q[k] = 0; owner_q[k] = 0;
            free_next[k] = (k == NH - 1) ? NONE : k + 1;
            newer_q[k] = 0; older_q[k] = 0;
        end
        free_head = 0; newest = NONE; oldest = NONE; used_bytes = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_eviction();
        write_capacity(600);
        test_random(100);
        write_capacity(3000);
        test_random(100);
        write_capacity(24'd1048576);
        test_random(70);
        drain();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
